>>> src/mca_pkg.sv
// Shared types and constants for the masked column aggregate.
// Depends on nothing; used by every module of the block.
`default_nettype none
package mca_pkg;
  localparam int CountWidthDef = 32;
  localparam int FractionBitsDef = 16;

  localparam logic [1:0] OpSum = 2'd0;
  localparam logic [1:0] OpMin = 2'd1;
  localparam logic [1:0] OpMax = 2'd2;
  localparam logic [1:0] OpDev = 2'd3;

  localparam logic [2:0] TypeU8 = 3'd0;
  localparam logic [2:0] TypeU16 = 3'd1;
  localparam logic [2:0] TypeS8 = 3'd2;
  localparam logic [2:0] TypeS16 = 3'd3;
  localparam logic [2:0] TypeS32 = 3'd4;
  localparam logic [2:0] TypeS64 = 3'd5;

  localparam logic [1:0] RegOperation = 2'd0;
  localparam logic [1:0] RegElementType = 2'd1;
  localparam logic [1:0] RegMeanFixed = 2'd2;

  // Column summary handed from the front end to the finishing back end.
  typedef struct packed {
    logic [63:0] value;
    logic [31:0] count;
    logic        any;
    logic        sat;
    logic        err;
    logic        dev;
  } col_sum_t;
endpackage
`default_nettype wire

>>> src/mca_front.sv
// Front end: extends, classifies and folds each element into column state.
// Depends on mca_pkg; feeds column summaries into the queue.
`default_nettype none
module mca_front #(
  parameter int COUNT_WIDTH = mca_pkg::CountWidthDef,
  parameter int FRACTION_BITS = mca_pkg::FractionBitsDef
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [63:0]      bits,
  input  wire logic             present,
  input  wire logic             last,
  input  wire logic [1:0]       op,
  input  wire logic [2:0]       etype,
  input  wire logic [63:0]      mean,
  output logic                  sum_valid,
  input  wire logic             sum_ready,
  output mca_pkg::col_sum_t     sum_data
);
  localparam logic [COUNT_WIDTH-1:0] CMax = '1;

  // Two-stage element path: stage 1 forms the deviation square, stage 2 folds.
  logic             s1_v_r, s1_pres_r, s1_last_r, s1_err_r, s1_big_r;
  logic [1:0]       s1_op_r;
  logic [63:0]      s1_x_r, s1_sq_r;
  logic [63:0]      run_r, sqs_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic             seen_r, sat_r;

  logic [63:0]  x;
  logic         err;
  logic [127:0] d;
  logic [127:0] ad;
  logic         big;
  logic         stall;

  always_comb begin
    case (etype)
      mca_pkg::TypeU8:  x = {56'd0, bits[7:0]};
      mca_pkg::TypeU16: x = {48'd0, bits[15:0]};
      mca_pkg::TypeS8:  x = {{56{bits[7]}}, bits[7:0]};
      mca_pkg::TypeS16: x = {{48{bits[15]}}, bits[15:0]};
      mca_pkg::TypeS32: x = {{32{bits[31]}}, bits[31:0]};
      default:          x = bits;
    endcase
    err = (etype > mca_pkg::TypeS64) ||
          (((op == mca_pkg::OpSum) || (op == mca_pkg::OpDev)) && (etype < mca_pkg::TypeS8));
    d = ({{64{x[63]}}, x} << FRACTION_BITS) - {{64{mean[63]}}, mean};
    ad = d[127] ? (~d + 128'd1) : d;
    big = (ad[127:32] != 96'd0);
  end

  // Stage 2 holds when its last element has nowhere to go.
  assign stall = s1_v_r && s1_last_r && !sum_ready;
  assign in_ready = !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!stall) begin
      s1_v_r <= in_valid;
    end
    if (!stall) begin
      s1_pres_r <= present;
      s1_last_r <= last;
      s1_err_r <= err;
      s1_big_r <= big;
      s1_op_r <= op;
      s1_x_r <= x;
      s1_sq_r <= ad[31:0] * ad[31:0];
    end
  end

  logic [63:0] run_nxt, sqs_nxt;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  logic seen_nxt, sat_nxt;
  logic [64:0] acc;

  always_comb begin
    run_nxt = run_r;
    sqs_nxt = sqs_r;
    cnt_nxt = cnt_r;
    seen_nxt = seen_r;
    sat_nxt = sat_r;
    acc = {1'b0, sqs_r} + {1'b0, s1_sq_r};
    if (s1_pres_r) begin
      if (!s1_err_r) begin
        case (s1_op_r)
          mca_pkg::OpSum: run_nxt = run_r + s1_x_r;
          mca_pkg::OpMin: if (!seen_r || ($signed(s1_x_r) < $signed(run_r))) run_nxt = s1_x_r;
          mca_pkg::OpMax: if (!seen_r || ($signed(run_r) < $signed(s1_x_r))) run_nxt = s1_x_r;
          default: begin
            if (sat_r || s1_big_r || acc[64]) begin
              sqs_nxt = '1;
              sat_nxt = 1'b1;
            end else begin
              sqs_nxt = acc[63:0];
            end
          end
        endcase
      end
      if (cnt_r != CMax) cnt_nxt = cnt_r + 1'b1;
      seen_nxt = 1'b1;
    end
  end

  always_comb begin
    sum_valid = s1_v_r && s1_last_r;
    sum_data.count = 32'(cnt_nxt);
    sum_data.any = seen_nxt;
    sum_data.err = s1_err_r;
    sum_data.dev = (s1_op_r == mca_pkg::OpDev);
    sum_data.sat = !s1_err_r && (s1_op_r == mca_pkg::OpDev) && seen_nxt && sat_nxt;
    sum_data.value = (s1_op_r == mca_pkg::OpDev) ? sqs_nxt : run_nxt;
  end

  // Column state folds each element; a delivered last element clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      sqs_r <= '0;
      cnt_r <= '0;
      seen_r <= 1'b0;
      sat_r <= 1'b0;
    end else if (s1_v_r && !stall) begin
      if (s1_last_r) begin
        run_r <= '0;
        sqs_r <= '0;
        cnt_r <= '0;
        seen_r <= 1'b0;
        sat_r <= 1'b0;
      end else begin
        run_r <= run_nxt;
        sqs_r <= sqs_nxt;
        cnt_r <= cnt_nxt;
        seen_r <= seen_nxt;
        sat_r <= sat_nxt;
      end
    end
  end
endmodule
`default_nettype wire

>>> src/mca_queue.sv
// Two-entry queue of column summaries between front and back ends.
// Depends on mca_pkg.
`default_nettype none
module mca_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire mca_pkg::col_sum_t wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output mca_pkg::col_sum_t      rd_data
);
  mca_pkg::col_sum_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] fill_r;

  assign wr_ready = (fill_r != 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign rd_data = mem_r[rp_r];

  // Pointers and fill level move on each transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      fill_r <= fill_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

>>> src/mca_back.sv
// Back end: divides a deviation column's squared sum by the count and takes the root.
// Depends on mca_pkg; drives the result register.
`default_nettype none
module mca_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire mca_pkg::col_sum_t q_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mca_pkg::col_sum_t      out_data
);
  typedef enum logic [1:0] {IDLE, DIVIDE, ROOT, SEND} state_t;
  state_t state_r;
  logic [6:0] step_r;
  logic [63:0] quo_r, rem_r, res_r, bit_r, n_r;
  mca_pkg::col_sum_t hold_r;

  logic [64:0] trial;
  logic [63:0] rs;
  mca_pkg::col_sum_t q_zero;

  assign q_ready = (state_r == IDLE);
  assign out_valid = (state_r == SEND);
  assign out_data = hold_r;

  always_comb begin
    trial = {rem_r, quo_r[63]} - {33'd0, hold_r.count};
    rs = res_r + bit_r;
    // Errored or empty columns report a zero value.
    q_zero = q_data;
    q_zero.value = '0;
  end

  // One quotient bit per cycle, then, after loading the radicand, one root bit pair per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      case (state_r)
        IDLE: begin
          if (q_valid) begin
            if (q_data.err || !q_data.any) begin
              hold_r <= q_zero;
              state_r <= SEND;
            end else if (q_data.dev) begin
              hold_r <= q_data;
              quo_r <= q_data.value;
              rem_r <= '0;
              step_r <= 7'd0;
              state_r <= DIVIDE;
            end else begin
              hold_r <= q_data;
              state_r <= SEND;
            end
          end
        end
        DIVIDE: begin
          if (!trial[64]) begin
            rem_r <= trial[63:0];
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[62:0], quo_r[63]};
            quo_r <= {quo_r[62:0], 1'b0};
          end
          if (step_r == 7'd63) begin
            state_r <= ROOT;
            res_r <= '0;
            bit_r <= 64'h4000_0000_0000_0000;
            step_r <= 7'd0;
          end else begin
            step_r <= step_r + 7'd1;
          end
        end
        ROOT: begin
          if (step_r == 7'd0) begin
            n_r <= quo_r;
            step_r <= 7'd1;
          end else begin
            if (n_r >= rs) begin
              n_r <= n_r - rs;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
            if (bit_r == 64'd1) begin
              hold_r.value <= (n_r >= rs) ? (res_r >> 1) + bit_r : res_r >> 1;
              state_r <= SEND;
            end
          end
        end
        SEND: if (out_ready) state_r <= IDLE;
        default: state_r <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/masked_column_aggregate.sv
// Top level of the masked column aggregate: config registers and wiring.
// Depends on mca_pkg, mca_front, mca_queue and mca_back.
`default_nettype none
// One element is taken per cycle while the front end is not stalled; the front
// end folds it into the column state through a two-stage path. Each last
// element sends a column summary through a two-entry queue to the back end,
// which takes the summary and sends it for sum, min and max; for the
// deviation it takes the summary, runs a restoring division by the count and a
// square root, then sends. Results leave through a registered output.
module masked_column_aggregate #(
  parameter int COUNT_WIDTH = mca_pkg::CountWidthDef,
  parameter int FRACTION_BITS = mca_pkg::FractionBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // element_bits[63:0], not_null[64], zeros
  input  wire logic        s_axis_tlast,  // last_element
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,  // result_value[63:0], present_count[95:64]
  output logic [2:0]       m_axis_tuser,  // any_present, deviation_saturated, error_code
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  logic [1:0]  op_r;
  logic [2:0]  etype_r;
  logic [63:0] mean_r;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= mca_pkg::OpSum;
      etype_r <= mca_pkg::TypeS64;
      mean_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mca_pkg::RegOperation:   op_r <= cfg_data[1:0];
        mca_pkg::RegElementType: etype_r <= cfg_data[2:0];
        mca_pkg::RegMeanFixed:   mean_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic sv, sr, qv, qr;
  mca_pkg::col_sum_t sd, qd, od;

  mca_front #(.COUNT_WIDTH(COUNT_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk, .rst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .bits(s_axis_tdata[63:0]), .present(s_axis_tdata[64]), .last(s_axis_tlast),
    .op(op_r), .etype(etype_r), .mean(mean_r),
    .sum_valid(sv), .sum_ready(sr), .sum_data(sd)
  );

  mca_queue u_queue (
    .clk, .rst_n, .wr_valid(sv), .wr_ready(sr), .wr_data(sd),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qd)
  );

  mca_back u_back (
    .clk, .rst_n, .q_valid(qv), .q_ready(qr), .q_data(qd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(od)
  );

  assign m_axis_tdata = {od.count, od.value};
  assign m_axis_tuser = {od.err, od.sat, od.any};
endmodule
`default_nettype wire
